// ===== rtl/ntfp_pkg.sv =====
// shared types and constants for the number to fixed point converter
package ntfp_pkg;

    typedef enum logic [1:0] {
        MODE_INT32   = 2'd0,
        MODE_INT64   = 2'd1,
        MODE_FLOAT32 = 2'd2,
        MODE_FLOAT64 = 2'd3
    } mode_t;

    // unpacked value: magnitude integer msb-aligned with a power of two
    // value = mant * 2^(exp - 63), mant[63] set when nonzero
    typedef struct packed {
        logic               valid;
        logic               is_zero;
        logic               is_nan;
        logic               is_inf;
        logic               neg;
        logic [63:0]        mant;
        logic signed [12:0] exp;
        logic signed [7:0]  top;
        logic [6:0]         wid;
    } unp_t;

    // fixed-point stage: truncated pattern before sign handling
    typedef struct packed {
        logic        valid;
        logic        neg;
        logic        ovf;
        logic [63:0] pat;
        logic [63:0] mask;
    } fix_t;

endpackage

// ===== rtl/number_to_fixed_point_bits.sv =====
// top level: four-stage converter from int or float to fixed-point bits
// Converts int32, int64, float32 or float64 raw values into a width-bit
// fixed-point pattern whose top bit weighs 2^top_bit_weight, truncating
// toward zero; on overflow the magnitude saturates to all ones before
// negation. A transaction is accepted every cycle while in_stall is low;
// it passes four register stages (decode, normalize, align, sign), and
// the whole pipe holds still while a held result is stalled. signed_mode
// must be written only while idle by the user; the block does not check.
module number_to_fixed_point_bits
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        mode,
    input  logic [63:0]       value_bits,
    input  logic signed [7:0] top_bit_weight,
    input  logic [6:0]        width,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [63:0]       pattern,
    output logic              overflowed
);
    import ntfp_pkg::*;

    logic signed_mode_reg;
    logic advance;
    unp_t unp;
    fix_t fix;
    logic out_valid_reg;
    logic [63:0] pattern_reg;
    logic overflowed_reg;

    // pipe moves when the output slot is empty or being taken
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            signed_mode_reg <= cfg_wdata;
        end
    end

    ntfp_unpack u_unpack
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .in_valid       (in_valid),
        .mode           (mode),
        .value_bits     (value_bits),
        .top_bit_weight (top_bit_weight),
        .width          (width),
        .unp            (unp)
    );

    ntfp_align u_align
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .unp     (unp),
        .fix     (fix)
    );

    // stage four: optional two's complement negation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= fix.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pattern_reg    <= (signed_mode_reg && fix.neg)
                              ? ((~fix.pat + 64'd1) & fix.mask) : fix.pat;
            overflowed_reg <= fix.ovf;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pattern    = pattern_reg;
    assign overflowed = overflowed_reg;

`ifndef SYNTHESIS
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped under stall");
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(pattern) && $stable(overflowed))
        else $error("result changed under stall");
    a_ovf_ones: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflowed && !signed_mode_reg |-> pattern[0])
        else $error("overflow without saturation");
`endif

endmodule

// ===== rtl/ntfp_unpack.sv =====
// stages one and two: type decode, int64 rounding, normalization
module ntfp_unpack
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               in_valid,
    input  logic [1:0]         mode,
    input  logic [63:0]        value_bits,
    input  logic signed [7:0]  top_bit_weight,
    input  logic [6:0]         width,
    output ntfp_pkg::unp_t     unp
);
    import ntfp_pkg::*;

    // stage one: raw magnitude as integer with exponent, not yet normalized
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_zero_reg, s1_nan_reg, s1_inf_reg, s1_neg_reg;
    logic [63:0]        s1_mag_reg;
    logic signed [12:0] s1_exp_reg;
    logic               s1_is_int64_reg;
    logic signed [7:0]  s1_top_reg;
    logic [6:0]         s1_wid_reg;

    logic               d_zero, d_nan, d_inf, d_neg;
    logic [63:0]        d_mag;
    logic signed [12:0] d_exp;
    logic [31:0]        lo;

    assign s1_valid_next = in_valid;
    assign lo = value_bits[31:0];

    // decode the raw value into sign, integer magnitude and exponent of its lsb
    always_comb
    begin
        d_zero = 1'b0;
        d_nan  = 1'b0;
        d_inf  = 1'b0;
        d_neg  = 1'b0;
        d_mag  = '0;
        d_exp  = '0;
        unique case (mode_t'(mode))
            MODE_INT32:
            begin
                d_neg = lo[31];
                d_mag = {32'd0, lo[31] ? (~lo + 32'd1) : lo};
                d_exp = 13'sd0;
            end
            MODE_INT64:
            begin
                d_neg = value_bits[63];
                d_mag = value_bits[63] ? (~value_bits + 64'd1) : value_bits;
                d_exp = 13'sd0;
            end
            MODE_FLOAT32:
            begin
                d_neg = lo[31];
                if (lo[30:23] == 8'hFF)
                begin
                    d_nan = (lo[22:0] != 23'd0);
                    d_inf = (lo[22:0] == 23'd0);
                end
                else if (lo[30:23] == 8'd0)
                begin
                    d_mag = {41'd0, lo[22:0]};
                    d_exp = -13'sd149;
                end
                else
                begin
                    d_mag = {40'd0, 1'b1, lo[22:0]};
                    d_exp = $signed({5'd0, lo[30:23]}) - 13'sd150;
                end
            end
            MODE_FLOAT64:
            begin
                d_neg = value_bits[63];
                if (value_bits[62:52] == 11'h7FF)
                begin
                    d_nan = (value_bits[51:0] != 52'd0);
                    d_inf = (value_bits[51:0] == 52'd0);
                end
                else if (value_bits[62:52] == 11'd0)
                begin
                    d_mag = {12'd0, value_bits[51:0]};
                    d_exp = -13'sd1074;
                end
                else
                begin
                    d_mag = {11'd0, 1'b1, value_bits[51:0]};
                    d_exp = $signed({2'd0, value_bits[62:52]}) - 13'sd1075;
                end
            end
            default: ;
        endcase
        d_zero = !d_nan && !d_inf && (d_mag == 64'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_zero_reg     <= d_zero;
            s1_nan_reg      <= d_nan;
            s1_inf_reg      <= d_inf;
            s1_neg_reg      <= d_neg && !d_zero;
            s1_mag_reg      <= d_mag;
            s1_exp_reg      <= d_exp;
            s1_is_int64_reg <= (mode_t'(mode) == MODE_INT64);
            s1_top_reg      <= top_bit_weight;
            s1_wid_reg      <= width;
        end
    end

    // stage two: leading zero count and normalizing shift
    logic [6:0]  lz;
    logic [63:0] norm;
    logic [63:0] rounded;
    logic        carry;
    logic signed [12:0] n_exp;
    logic        lsb, guard, sticky, rnd_up;

    always_comb
    begin
        lz = 7'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (s1_mag_reg[i])
            begin
                lz = 7'(63 - i);
            end
        end
    end

    assign norm = s1_mag_reg << lz[5:0];

    // int64 rounds to 53 significant bits, ties to even
    always_comb
    begin
        lsb     = norm[11];
        guard   = norm[10];
        sticky  = (norm[9:0] != 10'd0);
        rnd_up  = s1_is_int64_reg && guard && (sticky || lsb);
        carry   = 1'b0;
        rounded = norm;
        if (s1_is_int64_reg)
        begin
            {carry, rounded} = {1'b0, norm[63:11], 11'd0}
                               + (rnd_up ? 65'h800 : 65'd0);
        end
        n_exp = s1_exp_reg + 13'sd63 - $signed({6'd0, lz});
        if (carry)
        begin
            rounded = 64'h8000_0000_0000_0000;
            n_exp   = n_exp + 13'sd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unp <= '0;
        end
        else if (advance)
        begin
            unp.valid   <= s1_valid_reg;
            unp.is_zero <= s1_zero_reg;
            unp.is_nan  <= s1_nan_reg;
            unp.is_inf  <= s1_inf_reg;
            unp.neg     <= s1_neg_reg;
            unp.mant    <= rounded;
            unp.exp     <= n_exp;
            unp.top     <= s1_top_reg;
            unp.wid     <= s1_wid_reg;
        end
    end

endmodule

// ===== rtl/ntfp_align.sv =====
// stage three: place the normalized value on the fixed-point grid
module ntfp_align
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  ntfp_pkg::unp_t unp,
    output ntfp_pkg::fix_t fix
);
    import ntfp_pkg::*;

    logic [6:0]         w;
    logic [63:0]        mask;
    logic signed [12:0] msb_pos;
    logic signed [12:0] top_ext;
    logic signed [12:0] sh;
    logic [63:0]        shifted;
    logic               ovf;
    logic [63:0]        pat;

    always_comb
    begin
        w    = (unp.wid > 7'd64) ? 7'd64 : unp.wid;
        mask = (w == 7'd64) ? '1 : ((64'd1 << w[5:0]) - 64'd1);
        top_ext = 13'(unp.top);
        // msb of value sits at weight exp; lsb of output at top - w + 1
        msb_pos = unp.exp - (top_ext - $signed({6'd0, w}) + 13'sd1);
        ovf = unp.is_inf || (!unp.is_zero && (unp.exp > top_ext));
        sh  = 13'sd63 - msb_pos;
        if (unp.is_zero || unp.is_nan || sh > 13'sd63)
        begin
            shifted = '0;
        end
        else
        begin
            shifted = unp.mant >> sh[5:0];
        end
        pat = ovf ? mask : (shifted & mask);
        if (unp.is_nan || w == 7'd0)
        begin
            pat = '0;
            ovf = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fix <= '0;
        end
        else if (advance)
        begin
            fix.valid <= unp.valid;
            fix.neg   <= unp.neg && !unp.is_nan;
            fix.ovf   <= ovf;
            fix.pat   <= pat;
            fix.mask  <= mask;
        end
    end

endmodule

// ===== tb/number_to_fixed_point_bits_test.sv =====
// testbench for the number to fixed point converter with a scoreboard and random stimulus
`timescale 1ns / 1ps

// predicts conversion results and compares them with what the block delivers
class fixpt_scoreboard;
    bit          neg_mode;
    logic [63:0] exp_pattern[$];
    bit          exp_ovf[$];
    int          errors;

    // 2^e by repeated exact scaling
    function real pow2(int e);
        real r;
        r = 1.0;
        while (e > 0) begin r = r * 2.0; e--; end
        while (e < 0) begin r = r * 0.5; e++; end
        return r;
    endfunction

    // single precision bits widened to double
    function real single_to_real(logic [31:0] u);
        real r;
        logic [7:0] e;
        e = u[30:23];
        if (e == 8'hFF) begin
            if (u[22:0] != 0)
                return $bitstoreal(64'h7FF8_0000_0000_0000);
            return $bitstoreal({u[31], 11'h7FF, 52'd0});
        end
        if (e == 0) begin
            r = real'(u[22:0]) * pow2(-149);
            return u[31] ? -r : r;
        end
        return $bitstoreal({u[31], 11'(e + 11'd896), u[22:0], 29'd0});
    endfunction

    // nonnegative double below 2^64 truncated toward zero
    function logic [63:0] trunc_u64(real x);
        logic [63:0] b;
        logic [63:0] m;
        int e;
        b = $realtobits(x);
        e = int'(b[62:52]);
        m = {11'd0, 1'b1, b[51:0]};
        if (e < 1023)
            return 64'd0;
        if (e - 1023 >= 52)
            return m << (e - 1023 - 52);
        return m >> (52 - (e - 1023));
    endfunction

    // accepted input: work out the fixed-point pattern it must produce
    function void note_input(logic [1:0] md, logic [63:0] bits, logic signed [7:0] top,
                             logic [6:0] wd);
        int w;
        real val;
        real mag;
        real scaled;
        logic [63:0] mask;
        logic [63:0] pat;
        bit ovf;
        w = (wd > 64) ? 64 : int'(wd);
        pat = 0;
        ovf = 0;
        case (ntfp_pkg::mode_t'(md))
            ntfp_pkg::MODE_INT32:   val = real'($signed(bits[31:0]));
            ntfp_pkg::MODE_INT64:   val = real'($signed(bits));
            ntfp_pkg::MODE_FLOAT32: val = single_to_real(bits[31:0]);
            default:                val = $bitstoreal(bits);
        endcase
        if (w != 0 && val == val) begin
            mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
            mag = (val < 0.0) ? -val : val;
            if (mag >= pow2(int'(top) + 1)) begin
                pat = mask;
                ovf = 1;
            end else begin
                scaled = mag * pow2(w - 1 - int'(top));
                if (scaled >= 18446744073709551616.0)
                    pat = mask;
                else
                    pat = trunc_u64(scaled) & mask;
            end
            if (neg_mode && val < 0.0)
                pat = (~pat + 64'd1) & mask;
        end
        exp_pattern.push_back(pat);
        exp_ovf.push_back(ovf);
    endfunction

    // accepted result: compare with the oldest prediction
    function void check_result(logic [63:0] pat, logic ovf);
        logic [63:0] ep;
        bit eo;
        if (exp_pattern.size() == 0) begin
            $error("unexpected result pattern=%h overflowed=%b", pat, ovf);
            errors++;
            return;
        end
        ep = exp_pattern.pop_front();
        eo = exp_ovf.pop_front();
        if (pat !== ep) begin
            $error("pattern expected %h actual %h", ep, pat);
            errors++;
        end
        if (ovf !== eo) begin
            $error("overflowed expected %b actual %b", eo, ovf);
            errors++;
        end
    endfunction
endclass

module number_to_fixed_point_bits_test;
    import ntfp_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_wdata;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        mode;
    logic [63:0]       value_bits;
    logic signed [7:0] top_bit_weight;
    logic [6:0]        width;
    logic              out_valid;
    logic              out_stall;
    logic [63:0]       pattern;
    logic              overflowed;

    fixpt_scoreboard sb;
    int sent_count;
    int recv_count;

    number_to_fixed_point_bits DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .value_bits(value_bits),
        .top_bit_weight(top_bit_weight),
        .width(width),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .pattern(pattern),
        .overflowed(overflowed)
    );

    // clock
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // gap before a transaction, with bursts that never idle
    function int draw_gap(int n);
        if ((n / 100) % 3 == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    // offer one transaction, called at a falling edge, returns at a falling edge
    task send_value(logic [1:0] md, logic [63:0] bits, logic [7:0] top, logic [6:0] wd);
        int gap;
        gap = draw_gap(sent_count);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1;
        mode           <= md;
        value_bits     <= bits;
        top_bit_weight <= top;
        width          <= wd;
        do @(posedge clk); while (in_stall);
        sb.note_input(md, bits, top, wd);
        sent_count++;
        @(negedge clk);
    endtask

    // wait until every result is in, then update the sign register
    task write_sign_mode(bit val);
        in_valid <= 0;
        while (sb.exp_pattern.size() != 0) @(negedge clk);
        repeat (6) @(negedge clk);
        cfg_we    <= 1;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 0;
        sb.neg_mode = val;
        @(negedge clk);
    endtask

    // extremes and special cases
    task send_directed();
        send_value(MODE_INT32, 64'h0000_0000_7FFF_FFFF, 8'sd30, 7'd32);
        send_value(MODE_INT32, 64'hFFFF_FFFF_8000_0000, 8'sd31, 7'd33);
        send_value(MODE_INT32, 64'h1234_5678_FFFF_FFFF, 8'sd3, 7'd8);
        send_value(MODE_INT32, 64'd0, -8'sd128, 7'd64);
        send_value(MODE_INT64, 64'h7FFF_FFFF_FFFF_FFFF, 8'sd62, 7'd64);
        send_value(MODE_INT64, 64'h8000_0000_0000_0000, 8'sd63, 7'd64);
        send_value(MODE_INT64, 64'h0020_0000_0000_0001, 8'sd53, 7'd64);
        send_value(MODE_INT64, 64'hFFDF_FFFF_FFFF_FFFF, 8'sd60, 7'd61);
        send_value(MODE_FLOAT32, 64'h7FC0_0000, 8'sd0, 7'd16);
        send_value(MODE_FLOAT32, 64'h7F80_0000, 8'sd127, 7'd12);
        send_value(MODE_FLOAT32, 64'hFF80_0000, 8'sd5, 7'd12);
        send_value(MODE_FLOAT32, 64'h8000_0000, 8'sd0, 7'd10);
        send_value(MODE_FLOAT32, 64'h0000_0001, -8'sd128, 7'd64);
        send_value(MODE_FLOAT64, 64'h7FF8_0000_0000_0001, 8'sd0, 7'd8);
        send_value(MODE_FLOAT64, 64'h8000_0000_0000_0000, 8'sd1, 7'd4);
        send_value(MODE_FLOAT64, 64'h3FF8_0000_0000_0000, 8'sd1, 7'd4);
        send_value(MODE_FLOAT64, 64'hC006_0000_0000_0000, 8'sd2, 7'd6);
        send_value(MODE_FLOAT64, 64'h0000_0000_0000_0001, -8'sd128, 7'd64);
        send_value(MODE_FLOAT64, 64'h7FEF_FFFF_FFFF_FFFF, 8'sd127, 7'd64);
        send_value(MODE_FLOAT64, 64'hC006_0000_0000_0000, 8'sd2, 7'd0);
        send_value(MODE_FLOAT64, 64'h3FF8_0000_0000_0000, 8'sd0, 7'd127);
        send_value(MODE_FLOAT64, 64'hBFF0_0000_0000_0000, -8'sd1, 7'd1);
        send_value(MODE_INT32, 64'hFFFF_FFFF, 8'sd127, 7'd1);
    endtask

    // random transaction, mostly shaped so the value lands near the output range
    task send_random();
        logic [1:0]  md;
        logic [63:0] bits;
        logic [7:0]  top;
        logic [6:0]  wd;
        int e;
        md   = 2'($urandom_range(0, 3));
        bits = {$urandom, $urandom};
        top  = 8'($urandom);
        wd   = 7'($urandom_range(1, 64));
        if ($urandom_range(0, 9) == 0)
            wd = 7'($urandom);
        if ($urandom_range(0, 4) != 0)
        begin
            top = 8'($urandom_range(0, 100)) - 8'd40;
            case (md)
                MODE_INT32: bits = bits >> $urandom_range(0, 31);
                MODE_INT64: bits = bits >> $urandom_range(0, 63);
                MODE_FLOAT32:
                begin
                    e = int'($signed(top)) + 127 - int'($urandom_range(0, 30)) + 2;
                    if (e < 1) e = 1;
                    if (e > 254) e = 254;
                    bits[30:23] = 8'(e);
                end
                default:
                begin
                    e = int'($signed(top)) + 1023 - int'($urandom_range(0, 70)) + 2;
                    bits[62:52] = 11'(e);
                end
            endcase
            if ($urandom_range(0, 1) != 0 && md == MODE_INT64)
                bits = -bits;
            if ($urandom_range(0, 1) != 0 && md == MODE_INT32)
                bits[31:0] = -bits[31:0];
        end
        send_value(md, bits, top, wd);
    endtask

    // receiver with random stalls and one long hold-off
    initial
    begin
        int gap;
        out_stall = 1;
        recv_count = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = draw_gap(recv_count + 50);
            if (recv_count == 300)
                gap = 400;
            if (gap > 0)
            begin
                out_stall <= 1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 0;
            do @(posedge clk); while (!out_valid);
            sb.check_result(pattern, overflowed);
            recv_count++;
            @(negedge clk);
        end
    end

    // stimulus and end of run
    initial
    begin
        sb = new();
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        in_valid = 0;
        mode = MODE_INT32;
        value_bits = 0;
        top_bit_weight = 0;
        width = 0;
        sent_count = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        for (int ph = 0; ph < 4; ph++)
        begin
            write_sign_mode(1'(ph % 2));
            if (ph < 2)
                send_directed();
            repeat (300) send_random();
        end
        in_valid <= 0;
        while (sb.exp_pattern.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
